// ----- rtl/aescbc_pkg.sv -----
package aescbc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEXP,
    ST_LOAD,
    ST_ROUND,
    ST_FIN
  } st_t;

  typedef logic [7:0] sbox_tab_t [256];

  localparam logic [2:0] CFG_MODE  = 3'd0;
  localparam logic [2:0] CFG_KEY0  = 3'd1;
  localparam logic [2:0] CFG_KEY1  = 3'd2;
  localparam logic [2:0] CFG_KEY2  = 3'd3;
  localparam logic [2:0] CFG_KEY3  = 3'd4;
  localparam logic [2:0] CFG_IV_HI = 3'd5;
  localparam logic [2:0] CFG_IV_LO = 3'd6;

  localparam int unsigned NUM_ROUNDS = 14;
  localparam int unsigned KEY_ROWS   = 15;

  localparam sbox_tab_t SBOX = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic sbox_tab_t gen_inv_sbox();
    sbox_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[SBOX[i]] = 8'(i);
    end
    return t;
  endfunction

  localparam sbox_tab_t INV_SBOX = gen_inv_sbox();

  function automatic logic [7:0] rcon(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd1:    r = 8'h01;
      3'd2:    r = 8'h02;
      3'd3:    r = 8'h04;
      3'd4:    r = 8'h08;
      3'd5:    r = 8'h10;
      3'd6:    r = 8'h20;
      3'd7:    r = 8'h40;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a block sits at bits [127-8i -: 8]
  function automatic logic [7:0] get_b(input logic [127:0] s, input int i);
    return s[127 - 8 * i -: 8];
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s,
                                             input logic [127:0] k,
                                             input logic last);
    logic [127:0] t;
    logic [127:0] m;
    logic [7:0] a0, a1, a2, a3;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127 - 8 * (r + 4 * c) -: 8] = SBOX[get_b(s, r + 4 * ((c + r) % 4))];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = get_b(t, 4 * c);
      a1 = get_b(t, 4 * c + 1);
      a2 = get_b(t, 4 * c + 2);
      a3 = get_b(t, 4 * c + 3);
      m[127 - 32 * c -: 32] = {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                               a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                               a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                               xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
    end
    return (last ? t : m) ^ k;
  endfunction

  function automatic logic [7:0] gmul_inv(input logic [7:0] a, input logic [1:0] sel);
    logic [7:0] x2, x4, x8;
    logic [7:0] r;
    x2 = xt(a);
    x4 = xt(x2);
    x8 = xt(x4);
    unique case (sel)
      2'd0: r = x8 ^ x4 ^ x2;
      2'd1: r = x8 ^ x2 ^ a;
      2'd2: r = x8 ^ x4 ^ a;
      2'd3: r = x8 ^ a;
    endcase
    return r;
  endfunction

  function automatic logic [127:0] dec_round(input logic [127:0] s,
                                             input logic [127:0] k,
                                             input logic last);
    logic [127:0] t;
    logic [127:0] m;
    logic [7:0] a0, a1, a2, a3;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] = INV_SBOX[get_b(s, r + 4 * c)];
      end
    end
    t = t ^ k;
    // multipliers: e=0, b=1, d=2, 9=3
    for (int c = 0; c < 4; c++) begin
      a0 = get_b(t, 4 * c);
      a1 = get_b(t, 4 * c + 1);
      a2 = get_b(t, 4 * c + 2);
      a3 = get_b(t, 4 * c + 3);
      m[127 - 32 * c -: 32] = {
        gmul_inv(a0, 2'd0) ^ gmul_inv(a1, 2'd1) ^ gmul_inv(a2, 2'd2) ^ gmul_inv(a3, 2'd3),
        gmul_inv(a0, 2'd3) ^ gmul_inv(a1, 2'd0) ^ gmul_inv(a2, 2'd1) ^ gmul_inv(a3, 2'd2),
        gmul_inv(a0, 2'd2) ^ gmul_inv(a1, 2'd3) ^ gmul_inv(a2, 2'd0) ^ gmul_inv(a3, 2'd1),
        gmul_inv(a0, 2'd1) ^ gmul_inv(a1, 2'd2) ^ gmul_inv(a2, 2'd3) ^ gmul_inv(a3, 2'd0)};
    end
    return last ? t : m;
  endfunction

  function automatic logic [127:0] byte_mask(input logic [4:0] n);
    logic [127:0] m;
    for (int i = 0; i < 16; i++) begin
      m[127 - 8 * i -: 8] = (5'(i) < n) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

endpackage

// ----- rtl/aes256_cbc_block_cipher.sv -----
// channel  direction  handshake            payload
// in_      input      in_valid / in_stall  block_hi, block_lo, first_block, valid_bytes
// out_     output     out_valid / out_stall result_hi, result_lo, result_bytes
// cfg_     input      cfg_valid / cfg_ready index (0..6), data (64 bits)
//
// one block goes from acceptance to result through one load step (whitening key)
// and fourteen round steps on the single shared round unit, then one write to the
// output register once that is free; the round-key memory read sets the
// one-round-per-cycle pace; after reset or any key register write, key expansion
// fills the 15 round-key rows (one row per cycle) before the next block is accepted
// rst_n is synchronous; the result register holds while out_stall is high, and a new
// block is accepted while a finished result still waits
module aes256_cbc_block_cipher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_block_hi,
  input  logic [63:0] in_block_lo,
  input  logic        in_first_block,
  input  logic [4:0]  in_valid_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_hi,
  output logic [63:0] out_result_lo,
  output logic [4:0]  out_result_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  import aescbc_pkg::*;

  localparam int unsigned AW = $clog2(KEY_ROWS);

  st_t state_r, state_nxt;

  // configuration registers
  logic         decrypt_r;
  logic [255:0] key_r;
  logic [127:0] iv_r;
  logic         keys_cur_r;

  // chaining value and per-block working registers
  logic [127:0] chain_r;
  logic [127:0] chn_r;
  logic [127:0] blk_r;
  logic [127:0] st_r;
  logic [4:0]   n_r;
  logic [3:0]   step_r;

  // key expansion window and row counter
  logic [255:0] win_r;
  logic [3:0]   kcnt_r;

  // output register
  logic         out_valid_r;
  logic [127:0] out_data_r;
  logic [4:0]   out_bytes_r;

  logic         cfg_wr, key_wr, in_acc, out_free, last_step;
  logic         ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [127:0] ram_wdata, rk;
  logic [127:0] new_row, round_out, dec_out;
  logic [31:0]  kt;
  logic [4:0]   n_sat;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign key_wr    = cfg_wr && (cfg_index == CFG_KEY0 || cfg_index == CFG_KEY1 ||
                                cfg_index == CFG_KEY2 || cfg_index == CFG_KEY3);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign last_step = (step_r == 4'(NUM_ROUNDS));
  assign n_sat     = (in_valid_bytes > 5'd16) ? 5'd16 : in_valid_bytes;

  aescbc_ram #(.WIDTH(128), .DEPTH(KEY_ROWS)) u_rk_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rk)
  );

  // next key row: words 4k..4k+3 from the last eight words
  always_comb begin
    if (kcnt_r[0]) begin
      kt = sub_word(win_r[31:0]);
    end else begin
      kt = sub_word({win_r[23:0], win_r[31:24]}) ^ {rcon(kcnt_r[3:1]), 24'h0};
    end
    new_row[127:96] = win_r[255:224] ^ kt;
    new_row[95:64]  = win_r[223:192] ^ new_row[127:96];
    new_row[63:32]  = win_r[191:160] ^ new_row[95:64];
    new_row[31:0]   = win_r[159:128] ^ new_row[63:32];
  end

  assign round_out = decrypt_r ? dec_round(st_r, rk, last_step)
                               : enc_round(st_r, rk, last_step);
  assign dec_out   = (st_r ^ chn_r) & byte_mask(n_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_LOAD;
        end else if (!keys_cur_r && !key_wr) begin
          state_nxt = ST_KEXP;
        end
      end
      ST_KEXP: begin
        if (key_wr || kcnt_r == 4'(KEY_ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LOAD:  state_nxt = ST_ROUND;
      ST_ROUND: begin
        if (last_step) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and memory control
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = kcnt_r;
    ram_wdata = new_row;
    ram_raddr = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall  = !keys_cur_r;
        // whitening key: row 0 when encrypting, last row when decrypting
        ram_raddr = decrypt_r ? AW'(NUM_ROUNDS) : '0;
      end
      ST_KEXP: begin
        ram_we = 1'b1;
        if (kcnt_r == 4'd0) begin
          ram_wdata = win_r[255:128];
        end else if (kcnt_r == 4'd1) begin
          ram_wdata = win_r[127:0];
        end
      end
      ST_LOAD: begin
        ram_raddr = decrypt_r ? AW'(NUM_ROUNDS - 1) : AW'(1);
      end
      ST_ROUND: begin
        if (!last_step) begin
          ram_raddr = decrypt_r ? AW'(4'(NUM_ROUNDS) - step_r - 4'd1) : step_r + 4'd1;
        end
      end
      ST_FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      decrypt_r   <= 1'b0;
      key_r       <= '0;
      iv_r        <= '0;
      keys_cur_r  <= 1'b0;
      chain_r     <= '0;
      out_valid_r <= 1'b0;
      kcnt_r      <= '0;
      step_r      <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr) begin
        unique case (cfg_index)
          CFG_MODE:  decrypt_r        <= cfg_data[0];
          CFG_KEY0:  key_r[255:192]   <= cfg_data;
          CFG_KEY1:  key_r[191:128]   <= cfg_data;
          CFG_KEY2:  key_r[127:64]    <= cfg_data;
          CFG_KEY3:  key_r[63:0]      <= cfg_data;
          CFG_IV_HI: iv_r[127:64]     <= cfg_data;
          CFG_IV_LO: iv_r[63:0]       <= cfg_data;
          default: begin
          end
        endcase
      end

      if (key_wr) begin
        keys_cur_r <= 1'b0;
      end else if (state_r == ST_KEXP && kcnt_r == 4'(KEY_ROWS - 1)) begin
        keys_cur_r <= 1'b1;
      end

      if (state_r == ST_KEXP) begin
        kcnt_r <= kcnt_r + 4'd1;
      end else begin
        kcnt_r <= '0;
      end

      if (state_r == ST_LOAD) begin
        step_r <= 4'd1;
      end else if (state_r == ST_ROUND) begin
        step_r <= step_r + 4'd1;
      end

      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
        chain_r     <= decrypt_r ? blk_r : st_r;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      win_r <= key_r;
    end else if (state_r == ST_KEXP && kcnt_r >= 4'd2) begin
      win_r <= {win_r[127:0], new_row};
    end

    if (in_acc) begin
      chn_r <= in_first_block ? iv_r : chain_r;
      blk_r <= {in_block_hi, in_block_lo};
      n_r   <= n_sat;
      if (decrypt_r) begin
        st_r <= {in_block_hi, in_block_lo};
      end else begin
        st_r <= ({in_block_hi, in_block_lo} & byte_mask(n_sat)) ^
                (in_first_block ? iv_r : chain_r);
      end
    end else if (state_r == ST_LOAD) begin
      st_r <= st_r ^ rk;
    end else if (state_r == ST_ROUND) begin
      st_r <= round_out;
    end

    if (state_r == ST_FIN && out_free) begin
      out_data_r  <= decrypt_r ? dec_out : st_r;
      out_bytes_r <= decrypt_r ? n_r : 5'd16;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_hi    = out_data_r[127:64];
  assign out_result_lo    = out_data_r[63:0];
  assign out_result_bytes = out_bytes_r;

`ifndef SYNTHESIS
  a_acc_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_LOAD)
    else $error("accepted transaction did not start the load cycle");

  a_keys_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD || state_r == ST_ROUND) |-> keys_cur_r)
    else $error("rounds running on a stale key schedule");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result shown without a finished block");

  a_round_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && last_step) |=> state_r == ST_FIN)
    else $error("round count overran");
`endif

endmodule

// ----- rtl/aescbc_ram.sv -----
module aescbc_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- dv/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import aescbc_pkg::*;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        first;
    logic [4:0]  nbytes;
  } blk_txn_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  nbytes;
  } cipher_out_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_block_hi = '0;
  logic [63:0] in_block_lo = '0;
  logic        in_first_block = 1'b0;
  logic [4:0]  in_valid_bytes = 5'd16;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_result_hi;
  logic [63:0] out_result_lo;
  logic [4:0]  out_result_bytes;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_MODE;
  logic [63:0] cfg_data = '0;

  aes256_cbc_block_cipher dut (.*);

  always #5 clk = ~clk;

  // predictor state: its own copy of the registers and the chain
  logic        mdl_decrypt;
  logic [63:0] mdl_key [4];
  logic [63:0] mdl_iv_hi, mdl_iv_lo;
  logic [63:0] mdl_chain_hi, mdl_chain_lo;
  logic [7:0]  fwd_sbox [256];
  logic [7:0]  rev_sbox [256];

  blk_txn_t    pending_blocks[$];
  cipher_out_t expected_blocks[$];

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_off = 1'b0;
  int unsigned errors = 0;
  int unsigned n_sent = 0, n_recv = 0, n_enc = 0, n_dec = 0;
  longint unsigned cycle = 0;

  function automatic logic [7:0] gfm(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 0;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) p ^= a;
      a = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
      b >>= 1;
    end
    return p;
  endfunction

  // s-box generated from field inverses, independent of the package table
  task automatic build_sboxes();
    logic [7:0] inv, s;
    for (int x = 0; x < 256; x++) begin
      inv = 1;
      for (int i = 0; i < 254; i++) inv = gfm(inv, 8'(x));
      if (x == 0) inv = 0;
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      fwd_sbox[x] = s;
      rev_sbox[s] = 8'(x);
    end
  endtask

  function automatic logic [31:0] sbw(input logic [31:0] w);
    return {fwd_sbox[w[31:24]], fwd_sbox[w[23:16]], fwd_sbox[w[15:8]], fwd_sbox[w[7:0]]};
  endfunction

  function automatic void mix(ref logic [7:0] s[16], input bit inv);
    logic [7:0] m0, m1, m2, m3, a0, a1, a2, a3;
    m0 = inv ? 8'h0e : 8'h02; m1 = inv ? 8'h0b : 8'h03;
    m2 = inv ? 8'h0d : 8'h01; m3 = inv ? 8'h09 : 8'h01;
    for (int c = 0; c < 4; c++) begin
      a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
      s[4*c]   = gfm(a0, m0) ^ gfm(a1, m1) ^ gfm(a2, m2) ^ gfm(a3, m3);
      s[4*c+1] = gfm(a0, m3) ^ gfm(a1, m0) ^ gfm(a2, m1) ^ gfm(a3, m2);
      s[4*c+2] = gfm(a0, m2) ^ gfm(a1, m3) ^ gfm(a2, m0) ^ gfm(a3, m1);
      s[4*c+3] = gfm(a0, m1) ^ gfm(a1, m2) ^ gfm(a2, m3) ^ gfm(a3, m0);
    end
  endfunction

  function automatic cipher_out_t cbc_predict(input blk_txn_t t);
    logic [31:0] w [60];
    logic [31:0] tw;
    logic [7:0]  st[16], tmp[16], bl[16], ch[16];
    logic [127:0] packed_st;
    logic [127:0] blk_w, chn_w;
    int unsigned n;
    cipher_out_t r;
    for (int i = 0; i < 4; i++) begin
      w[2*i] = mdl_key[i][63:32];
      w[2*i+1] = mdl_key[i][31:0];
    end
    for (int i = 8; i < 60; i++) begin
      tw = w[i-1];
      if (i % 8 == 0) tw = sbw({tw[23:0], tw[31:24]}) ^ ({8'h01 << (i/8 - 1), 24'h0});
      else if (i % 8 == 4) tw = sbw(tw);
      w[i] = w[i-8] ^ tw;
    end
    n = (t.nbytes > 16) ? 16 : t.nbytes;
    if (t.first) begin
      mdl_chain_hi = mdl_iv_hi;
      mdl_chain_lo = mdl_iv_lo;
    end
    blk_w = {t.hi, t.lo};
    chn_w = {mdl_chain_hi, mdl_chain_lo};
    for (int i = 0; i < 16; i++) begin
      bl[i] = blk_w[127-8*i -: 8];
      ch[i] = chn_w[127-8*i -: 8];
    end
    if (!mdl_decrypt) begin
      for (int i = 0; i < 16; i++) st[i] = ((i < n) ? bl[i] : 8'h00) ^ ch[i];
      for (int rd = 0; rd <= 14; rd++) begin
        if (rd > 0) begin
          for (int i = 0; i < 16; i++) st[i] = fwd_sbox[st[i]];
          for (int rr = 0; rr < 4; rr++)
            for (int c = 0; c < 4; c++) tmp[rr+4*c] = st[rr+4*((c+rr)%4)];
          st = tmp;
          if (rd != 14) mix(st, 1'b0);
        end
        for (int i = 0; i < 16; i++) st[i] ^= w[4*rd + i/4][31-8*(i%4) -: 8];
      end
      r.nbytes = 5'd16;
    end else begin
      st = bl;
      for (int i = 0; i < 16; i++) st[i] ^= w[56 + i/4][31-8*(i%4) -: 8];
      for (int rd = 13; rd >= 0; rd--) begin
        for (int rr = 0; rr < 4; rr++)
          for (int c = 0; c < 4; c++) tmp[rr+4*((c+rr)%4)] = st[rr+4*c];
        st = tmp;
        for (int i = 0; i < 16; i++) st[i] = rev_sbox[st[i]];
        for (int i = 0; i < 16; i++) st[i] ^= w[4*rd + i/4][31-8*(i%4) -: 8];
        if (rd != 0) mix(st, 1'b1);
      end
      for (int i = 0; i < 16; i++) st[i] = (i < n) ? (st[i] ^ ch[i]) : 8'h00;
      r.nbytes = 5'(n);
    end
    for (int i = 0; i < 16; i++) packed_st[127-8*i -: 8] = st[i];
    r.hi = packed_st[127:64];
    r.lo = packed_st[63:0];
    // chain takes the ciphertext in both directions
    if (mdl_decrypt) begin
      mdl_chain_hi = t.hi; mdl_chain_lo = t.lo;
    end else begin
      mdl_chain_hi = r.hi; mdl_chain_lo = r.lo;
    end
    return r;
  endfunction

  // driver: offers the head of the pending queue, predicts on acceptance
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_blocks.push_back(cbc_predict(pending_blocks.pop_front()));
        n_sent++;
        if (mdl_decrypt) n_dec++; else n_enc++;
      end
      if ((!in_valid || !in_stall) && pending_blocks.size() > 0 &&
          ($urandom_range(99) >= sender_idle_pct)) begin
        in_valid <= 1'b1;
        in_block_hi <= pending_blocks[0].hi;
        in_block_lo <= pending_blocks[0].lo;
        in_first_block <= pending_blocks[0].first;
        in_valid_bytes <= pending_blocks[0].nbytes;
      end else if (!in_valid || !in_stall) begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks each accepted result against the oldest expectation
  always @(posedge clk) begin
    cipher_out_t e;
    cycle++;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_recv++;
        if (expected_blocks.size() == 0) begin
          $error("unexpected result transaction hi=%h lo=%h", out_result_hi, out_result_lo);
          errors++;
        end else begin
          e = expected_blocks.pop_front();
          if (out_result_hi !== e.hi) begin
            $error("result_hi expected %h actual %h", e.hi, out_result_hi); errors++;
          end
          if (out_result_lo !== e.lo) begin
            $error("result_lo expected %h actual %h", e.lo, out_result_lo); errors++;
          end
          if (out_result_bytes !== e.nbytes) begin
            $error("result_bytes expected %0d actual %0d", e.nbytes, out_result_bytes);
            errors++;
          end
        end
      end
      out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // timeout watchdog
  always @(posedge clk) begin
    if (cycle > 2_000_000) begin
      $display("aes256_cbc_block_cipher test failed");
      $finish;
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MODE:  mdl_decrypt = val[0];
      CFG_KEY0:  mdl_key[0] = val;
      CFG_KEY1:  mdl_key[1] = val;
      CFG_KEY2:  mdl_key[2] = val;
      CFG_KEY3:  mdl_key[3] = val;
      CFG_IV_HI: mdl_iv_hi = val;
      CFG_IV_LO: mdl_iv_lo = val;
      default: ;
    endcase
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // wait for every expected result, then let the block settle
  task automatic drain();
    while (pending_blocks.size() > 0 || in_valid || expected_blocks.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic push_blk(input logic [63:0] hi, input logic [63:0] lo,
                          input logic first, input logic [4:0] nb);
    blk_txn_t t;
    t.hi = hi; t.lo = lo; t.first = first; t.nbytes = nb;
    pending_blocks.push_back(t);
  endtask

  // message-shaped traffic: a first block, then a chain with occasional restarts, mostly full blocks
  task automatic push_random(input int unsigned count);
    logic [4:0] nb;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: nb = 5'($urandom_range(31));
        1, 2: nb = 5'($urandom_range(1, 15));
        default: nb = 5'd16;
      endcase
      push_blk(rnd64(), rnd64(), ($urandom_range(7) == 0) || i == 0, nb);
    end
  endtask

  task automatic random_key_iv();
    for (int i = 0; i < 4; i++) cfg_write(CFG_KEY0 + 3'(i), rnd64());
    cfg_write(CFG_IV_HI, rnd64());
    cfg_write(CFG_IV_LO, rnd64());
  endtask

  initial begin
    mdl_decrypt = 0;
    for (int i = 0; i < 4; i++) mdl_key[i] = '0;
    mdl_iv_hi = '0; mdl_iv_lo = '0;
    mdl_chain_hi = '0; mdl_chain_lo = '0;
    build_sboxes();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset key and chain, field extremes, odd valid counts
    push_blk('0, '0, 1'b0, 5'd16);
    push_blk('1, '1, 1'b0, 5'd16);
    push_blk(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1, 5'd1);
    push_blk('1, '1, 1'b0, 5'd0);
    push_blk('1, '1, 1'b0, 5'd31);
    push_blk(rnd64(), rnd64(), 1'b0, 5'd17);
    drain();

    // known key, an encrypt stream then a decrypt stream of fresh random blocks
    cfg_write(CFG_KEY0, 64'h0001020304050607);
    cfg_write(CFG_KEY1, 64'h08090a0b0c0d0e0f);
    cfg_write(CFG_KEY2, 64'h1011121314151617);
    cfg_write(CFG_KEY3, 64'h18191a1b1c1d1e1f);
    cfg_write(CFG_IV_HI, '1);
    cfg_write(CFG_IV_LO, '1);
    for (int nb = 0; nb <= 16; nb += 4) push_blk(rnd64(), rnd64(), nb == 0, 5'(nb));
    drain();
    cfg_write(CFG_MODE, 64'h1);
    for (int nb = 0; nb <= 16; nb += 4) push_blk(rnd64(), rnd64(), nb == 0, 5'(nb));
    push_blk('1, '0, 1'b1, 5'd31);
    drain();

    // random phases over the idling patterns and both directions
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin sender_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      cfg_write(CFG_MODE, 64'($urandom_range(1)));
      if (ph == 4) begin
        for (int i = 0; i < 4; i++) cfg_write(CFG_KEY0 + 3'(i), '1);
        cfg_write(CFG_IV_HI, '0);
        cfg_write(CFG_IV_LO, '0);
      end else begin
        random_key_iv();
      end
      // long receiver hold-off, timed in its own process while the sender keeps offering
      if (ph == 0) begin
        hold_off = 1'b1;
        fork
          begin
            repeat (300) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      push_random(135);
      drain();
    end

    $display("covered %0d blocks (%0d encrypt, %0d decrypt), %0d results checked",
             n_sent, n_enc, n_dec, n_recv);
    if (errors == 0 && expected_blocks.size() == 0) begin
      $display("aes256_cbc_block_cipher test passed");
    end else begin
      $display("aes256_cbc_block_cipher test failed");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/aescbc_pkg.sv
rtl/aescbc_ram.sv
rtl/aes256_cbc_block_cipher.sv
dv/tb.sv
